// File: src/bmp24_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types, constants and helpers for the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bmp24_pkg;

   // Largest width or height accepted from the header
   localparam int MAX_DIM      = 4096;
   // Counter width that holds 0 .. MAX_DIM
   localparam int DIM_W        = $clog2(MAX_DIM + 1);
   // Reported position and dimension widths
   localparam int POS_W        = 12;
   localparam int IMG_W        = 13;
   localparam int HDR_CNT_W    = 6;
   localparam int HEADER_BYTES = 54;
   localparam int BPP_24       = 24;

   // Result kinds
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [POS_W-1:0] pixel_row;
      logic [POS_W-1:0] pixel_col;
      logic [IMG_W-1:0] image_width;
      logic [IMG_W-1:0] image_height;
      logic             last_pixel;
   } rsp_type;

   // Saturate a 32-bit header word to the reported dimension width
   function automatic logic [IMG_W-1:0] sat_dim(input logic [31:0] v);
      logic [31:0] lim;
      lim = 32'((1 << IMG_W) - 1);
      if (v > lim) begin
         sat_dim = IMG_W'(lim);
      end else begin
         sat_dim = IMG_W'(v);
      end
   endfunction

endpackage
`default_nettype wire

// File: src/bmp24_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_parser
// Header capture, pixel assembly and row padding for one byte per step.
// ----------------------------------------------------------------------------
module bmp24_parser
   import bmp24_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type req,
   output logic         res_valid,
   output rsp_type      res
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_PIXEL  = 2'd1;
   localparam logic [1:0] PH_IDLE   = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [HDR_CNT_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]          width_ff, width_in;
   logic [31:0]          height_ff, height_in;
   logic [15:0]          depth_ff, depth_in;
   logic [1:0]           bip_ff, bip_in;
   logic [7:0]           blue_ff, blue_in;
   logic [7:0]           green_ff, green_in;
   logic [DIM_W-1:0]     col_ff, col_in;
   logic [DIM_W-1:0]     row_ff, row_in;
   logic [1:0]           pad_ff, pad_in;

   // Restart view of the state when the start flag is set
   logic [1:0]           cur_phase;
   logic [HDR_CNT_W-1:0] cur_cnt;
   logic [31:0]          cur_width, cur_height;
   logic [15:0]          cur_depth;
   logic [1:0]           cur_bip, cur_pad;
   logic [DIM_W-1:0]     cur_col, cur_row;
   logic [DIM_W-1:0]     col_next, row_next;
   logic [7:0]           b;
   logic                 bad;

   always_comb begin
      b          = req.data_byte;
      cur_phase  = req.start_of_file ? PH_HEADER : phase_ff;
      cur_cnt    = req.start_of_file ? '0 : hdr_cnt_ff;
      cur_width  = req.start_of_file ? '0 : width_ff;
      cur_height = req.start_of_file ? '0 : height_ff;
      cur_depth  = req.start_of_file ? '0 : depth_ff;
      cur_bip    = req.start_of_file ? '0 : bip_ff;
      cur_pad    = req.start_of_file ? '0 : pad_ff;
      cur_col    = req.start_of_file ? '0 : col_ff;
      cur_row    = req.start_of_file ? '0 : row_ff;
      col_next   = cur_col + DIM_W'(1);
      row_next   = cur_row + DIM_W'(1);

      bad = (cur_depth != 16'(BPP_24)) ||
            (cur_width == '0) || (cur_width > 32'(MAX_DIM)) ||
            (cur_height == '0) || (cur_height > 32'(MAX_DIM));

      phase_in   = cur_phase;
      hdr_cnt_in = cur_cnt;
      width_in   = cur_width;
      height_in  = cur_height;
      depth_in   = cur_depth;
      bip_in     = cur_bip;
      pad_in     = cur_pad;
      col_in     = cur_col;
      row_in     = cur_row;
      blue_in    = blue_ff;
      green_in   = green_ff;

      res_valid        = 1'b0;
      res              = '0;
      res.image_width  = sat_dim(cur_width);
      res.image_height = sat_dim(cur_height);

      unique case (cur_phase)
         PH_HEADER: begin
            // Merge the kept header fields, little-endian
            case (cur_cnt)
               6'd18: width_in[7:0]    = cur_width[7:0] | b;
               6'd19: width_in[15:8]   = cur_width[15:8] | b;
               6'd20: width_in[23:16]  = cur_width[23:16] | b;
               6'd21: width_in[31:24]  = cur_width[31:24] | b;
               6'd22: height_in[7:0]   = cur_height[7:0] | b;
               6'd23: height_in[15:8]  = cur_height[15:8] | b;
               6'd24: height_in[23:16] = cur_height[23:16] | b;
               6'd25: height_in[31:24] = cur_height[31:24] | b;
               6'd28: depth_in[7:0]    = cur_depth[7:0] | b;
               6'd29: depth_in[15:8]   = cur_depth[15:8] | b;
               default: ;
            endcase
            hdr_cnt_in = cur_cnt + HDR_CNT_W'(1);
            // Judge the header on its last byte
            if (cur_cnt == HDR_CNT_W'(HEADER_BYTES - 1)) begin
               res_valid = 1'b1;
               if (bad) begin
                  res.kind = KIND_ERROR;
                  phase_in = PH_IDLE;
               end else begin
                  res.kind = KIND_HEADER;
                  phase_in = PH_PIXEL;
                  bip_in   = '0;
                  col_in   = '0;
                  row_in   = '0;
                  pad_in   = '0;
               end
            end
         end
         PH_PIXEL: begin
            if (cur_pad != '0) begin
               // Drop a row pad byte
               pad_in = cur_pad - 2'd1;
            end else if (cur_bip == 2'd0) begin
               blue_in = b;
               bip_in  = 2'd1;
            end else if (cur_bip == 2'd1) begin
               green_in = b;
               bip_in   = 2'd2;
            end else begin
               // Emit the pixel and advance column and row
               bip_in        = 2'd0;
               res_valid     = 1'b1;
               res.kind      = KIND_PIXEL;
               res.red       = b;
               res.green     = green_ff;
               res.blue      = blue_ff;
               res.pixel_row = POS_W'(cur_row);
               res.pixel_col = POS_W'(cur_col);
               col_in        = col_next;
               if (32'(col_next) >= cur_width) begin
                  col_in = '0;
                  row_in = row_next;
                  if (32'(row_next) >= cur_height) begin
                     res.last_pixel = 1'b1;
                     phase_in       = PH_IDLE;
                  end else begin
                     pad_in = cur_width[1:0];
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // Hold state between accepted bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         depth_ff   <= '0;
         bip_ff     <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         pad_ff     <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         depth_ff   <= depth_in;
         bip_ff     <= bip_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         pad_ff     <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
      end
   end

   a_pad_in_pixel: assert property (@(posedge clock) disable iff (reset)
      (pad_ff != 2'd0) |-> (phase_ff == PH_PIXEL))
      else $error("pad bytes pending outside pixel phase");

   a_bip_in_pixel: assert property (@(posedge clock) disable iff (reset)
      (bip_ff != 2'd0) |-> (phase_ff == PH_PIXEL && pad_ff == 2'd0))
      else $error("partial pixel outside pixel phase or during padding");

   a_hdr_cnt_range: assert property (@(posedge clock) disable iff (reset)
      hdr_cnt_ff <= HDR_CNT_W'(HEADER_BYTES))
      else $error("header byte count past the header length");

endmodule
`default_nettype wire

// File: src/bmp24_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Byte-stream decoder for uncompressed 24-bit BMP files.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one file byte per transaction; start_of_file marks the
//          first byte of a file and restarts the parser on that byte.
//   rsp_*  carries results: one header verdict (accepted or error) after
//          header byte 53, then one pixel per three data bytes with its row
//          and column. Pad bytes and header bytes give no transaction.
// Timing: a result is registered and appears on rsp_valid in the cycle
//   after the byte that completes it is accepted.
// Throughput: one byte per cycle unless stalled; the parser updates its
//   counters in a single pass from request handshake to result register.
// Stall: the result register holds while rsp_ready is low; req_ready stays
//   high if the register is empty or is taken in the same cycle.
// Reset: the parser enters the header phase with all counters cleared and
//   the result register empty. After an error or the last pixel, bytes are
//   dropped until the next start_of_file.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder
   import bmp24_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    step;
   logic    res_valid;
   rsp_type res;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   bmp24_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (req_data),
      .res_valid (res_valid),
      .res       (res)
   );

   // Load a new result or drop the delivered one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last_pixel) |-> (rsp_data_ff.kind == KIND_PIXEL))
      else $error("last_pixel on a non-pixel result");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.kind == KIND_PIXEL) |->
      (IMG_W'(rsp_data_ff.pixel_col) < rsp_data_ff.image_width))
      else $error("pixel column beyond image width");

   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.kind != KIND_PIXEL) |->
      (rsp_data_ff.red == 8'd0 && rsp_data_ff.green == 8'd0 &&
       rsp_data_ff.blue == 8'd0 && rsp_data_ff.pixel_row == '0 &&
       rsp_data_ff.pixel_col == '0))
      else $error("header result carries pixel data");

endmodule
`default_nettype wire
